FILE: rtl/segment_allocator_first_best_fit_macros.svh
// ---------------------------------------------------------------------------
// segment allocator assertion macros
// concurrent assertion wrappers, empty when synthesizing
// ---------------------------------------------------------------------------
`ifndef SEGMENT_ALLOCATOR_FIRST_BEST_FIT_MACROS_SVH
`define SEGMENT_ALLOCATOR_FIRST_BEST_FIT_MACROS_SVH
`ifndef SYNTHESIS
`define SAFBF_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("safbf assertion failed");
`define SAFBF_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("safbf assertion failed");
`else
`define SAFBF_ASSERT_IMP(label, clk, rstn, ante, cons)
`define SAFBF_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif
`endif

FILE: rtl/safbf_pkg.sv
// ---------------------------------------------------------------------------
// safbf_pkg
// shared codes, defaults and state type of the segment allocator
// ---------------------------------------------------------------------------
package safbf_pkg;

    localparam int     DEF_MAX_SEGMENTS = 64;
    localparam longint DEF_ARENA_UNITS  = 65536;

    localparam int OP_W     = 2;
    localparam int OWNER_W  = 8;
    localparam int REQ_W    = 17;
    localparam int STATUS_W = 2;
    localparam int ADDR_W   = 16;

    localparam logic [OP_W-1:0] OP_ALLOC    = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE     = 2'd1;
    localparam logic [OP_W-1:0] OP_COALESCE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_FIT    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    localparam logic FIT_FIRST = 1'b0;

    typedef enum logic [8:0] {
        S_IDLE      = 9'b000000001,
        S_WALK      = 9'b000000010,
        S_PLACE     = 9'b000000100,
        S_SPLIT_NEW = 9'b000001000,
        S_SPLIT_OWN = 9'b000010000,
        S_CO_FIRST  = 9'b000100000,
        S_CO_WALK   = 9'b001000000,
        S_CO_END    = 9'b010000000,
        S_FINISH    = 9'b100000000
    } state_t;

endpackage

FILE: rtl/safbf_table.sv
// ---------------------------------------------------------------------------
// safbf_table
// segment record memory, one read and one write port, plus entry-used bits
// ---------------------------------------------------------------------------
module safbf_table #(
    parameter int     MAX_SEGMENTS = safbf_pkg::DEF_MAX_SEGMENTS,
    parameter longint ARENA_UNITS  = safbf_pkg::DEF_ARENA_UNITS,
    parameter int     IDX_W        = $clog2(MAX_SEGMENTS),
    parameter int     LINK_W       = $clog2(MAX_SEGMENTS + 1),
    parameter int     START_W      = $clog2(ARENA_UNITS),
    parameter int     SIZE_W       = $clog2(ARENA_UNITS + 1)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          rd_en,
    input  logic [IDX_W-1:0]              rd_addr,
    output logic [START_W-1:0]            rd_start,
    output logic [SIZE_W-1:0]             rd_size,
    output logic                          rd_free,
    output logic [safbf_pkg::OWNER_W-1:0] rd_owner,
    output logic [LINK_W-1:0]             rd_link,
    input  logic                          wr_en,
    input  logic [IDX_W-1:0]              wr_addr,
    input  logic [START_W-1:0]            wr_start,
    input  logic [SIZE_W-1:0]             wr_size,
    input  logic                          wr_free,
    input  logic [safbf_pkg::OWNER_W-1:0] wr_owner,
    input  logic [LINK_W-1:0]             wr_link,
    input  logic                          use_set,
    input  logic                          use_clr,
    input  logic [IDX_W-1:0]              use_idx,
    input  logic [IDX_W-1:0]              scan_idx,
    output logic                          scan_used
);
    import safbf_pkg::*;

    localparam int REC_W = START_W + SIZE_W + 1 + OWNER_W + LINK_W;

    logic [REC_W-1:0]        mem [MAX_SEGMENTS];
    logic [REC_W-1:0]        rdata_reg;
    logic                    head_fresh_reg;
    logic                    rd_head_reg;
    logic [MAX_SEGMENTS-1:0] used_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= {wr_start, wr_size, wr_free, wr_owner, wr_link};
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // entry zero reads as the whole free arena until it is first written
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_fresh_reg <= 1'b1;
            rd_head_reg    <= 1'b0;
        end else begin
            if (wr_en && (wr_addr == '0)) begin
                head_fresh_reg <= 1'b0;
            end
            if (rd_en) begin
                rd_head_reg <= head_fresh_reg && (rd_addr == '0);
            end
        end
    end

    always_comb begin
        if (rd_head_reg) begin
            rd_start = '0;
            rd_size  = SIZE_W'(ARENA_UNITS);
            rd_free  = 1'b1;
            rd_owner = '0;
            rd_link  = LINK_W'(MAX_SEGMENTS);
        end else begin
            {rd_start, rd_size, rd_free, rd_owner, rd_link} = rdata_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= MAX_SEGMENTS'(1);
        end else if (use_set) begin
            used_reg[use_idx] <= 1'b1;
        end else if (use_clr) begin
            used_reg[use_idx] <= 1'b0;
        end
    end

    assign scan_used = used_reg[scan_idx];

endmodule

FILE: rtl/segment_allocator_first_best_fit.sv
// ---------------------------------------------------------------------------
// segment_allocator_first_best_fit
// address-ordered segment table with first-fit / best-fit allocate, free, coalesce
// ---------------------------------------------------------------------------
// Input beats on s_* carry an operation, an owner id and a request size; each
// beat yields exactly one result beat on m_* with a status and a start address.
// cfg_fit_mode selects first fit (0) or best fit (1); write it only while idle.
// One operation is in flight at a time. The segment list lives in a memory
// with a registered read port and is followed one entry per cycle through the
// link field, so the cost is set by the list walk:
//   allocate: the walk of visited entries, a wait on the unused-entry scan
//             when a split needs a new entry, then the table writes
//   free:     the walk of visited entries up to the matching segment
//   coalesce: the walk of visited links, at most 2*MAX_SEGMENTS links
// A finished result moves to the output register; while that register holds
// an untaken result, the block keeps the new one and waits before returning to idle.
// Reset (aresetn low, synchronous) leaves one free segment covering the whole
// arena and fit mode at first fit; no clearing pass is needed.
// ---------------------------------------------------------------------------
`include "segment_allocator_first_best_fit_macros.svh"

module segment_allocator_first_best_fit #(
    parameter int     MAX_SEGMENTS = safbf_pkg::DEF_MAX_SEGMENTS,
    parameter longint ARENA_UNITS  = safbf_pkg::DEF_ARENA_UNITS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic                           cfg_fit_mode,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [safbf_pkg::OP_W-1:0]     s_operation,
    input  logic [safbf_pkg::OWNER_W-1:0]  s_owner_id,
    input  logic [safbf_pkg::REQ_W-1:0]    s_request_size,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [safbf_pkg::STATUS_W-1:0] m_status,
    output logic [safbf_pkg::ADDR_W-1:0]   m_start_address
);
    import safbf_pkg::*;

    localparam int IDX_W   = $clog2(MAX_SEGMENTS);
    localparam int LINK_W  = $clog2(MAX_SEGMENTS + 1);
    localparam int START_W = $clog2(ARENA_UNITS);
    localparam int SIZE_W  = $clog2(ARENA_UNITS + 1);
    localparam int CMP_W   = (SIZE_W > REQ_W) ? SIZE_W : REQ_W;
    localparam int STEP_W  = $clog2(2 * MAX_SEGMENTS);
    localparam logic [LINK_W-1:0] LINK_NONE    = LINK_W'(MAX_SEGMENTS);
    localparam logic [STEP_W-1:0] WALK_LAST    = STEP_W'(MAX_SEGMENTS - 1);
    localparam logic [STEP_W-1:0] CO_LAST      = STEP_W'(2 * MAX_SEGMENTS - 1);
    localparam logic [IDX_W-1:0]  SCAN_LAST    = IDX_W'(MAX_SEGMENTS - 1);

    state_t state_reg, state_next;

    logic                fit_mode_reg;
    logic [OP_W-1:0]     op_reg;
    logic [OWNER_W-1:0]  owner_reg;
    logic [REQ_W-1:0]    req_reg;
    logic [IDX_W-1:0]    cur_reg;
    logic [IDX_W-1:0]    nx_reg;
    logic [STEP_W-1:0]   steps_reg;
    logic                pick_valid_reg;
    logic [IDX_W-1:0]    pick_idx_reg;
    logic [START_W-1:0]  pick_start_reg;
    logic [SIZE_W-1:0]   pick_size_reg;
    logic [LINK_W-1:0]   pick_link_reg;
    logic [SIZE_W-1:0]   own_size_reg;
    logic [LINK_W-1:0]   own_link_reg;
    logic [START_W-1:0]  c_start_reg;
    logic [SIZE_W-1:0]   c_size_reg;
    logic                c_free_reg;
    logic [OWNER_W-1:0]  c_owner_reg;
    logic [LINK_W-1:0]   c_link_reg;
    logic                scan_busy_reg;
    logic                scan_found_reg;
    logic [IDX_W-1:0]    scan_idx_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic [START_W-1:0]  res_start_reg;
    logic                m_valid_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [ADDR_W-1:0]   m_addr_reg;

    logic                rd_en, wr_en, use_set, use_clr, scan_used;
    logic [IDX_W-1:0]    rd_addr, wr_addr, use_idx;
    logic [START_W-1:0]  rd_start, wr_start;
    logic [SIZE_W-1:0]   rd_size, wr_size;
    logic                rd_free, wr_free;
    logic [OWNER_W-1:0]  rd_owner, wr_owner;
    logic [LINK_W-1:0]   rd_link, wr_link;

    logic                s_fire, out_free;
    logic                hit_alloc, hit_free, better, walk_last, co_last, merged;
    logic [IDX_W-1:0]    rd_link_idx;
    logic [START_W-1:0]  split_start;
    logic [SIZE_W-1:0]   split_size;
    logic [63:0]         res_start_ext;

    safbf_table #(
        .MAX_SEGMENTS(MAX_SEGMENTS),
        .ARENA_UNITS (ARENA_UNITS),
        .IDX_W       (IDX_W),
        .LINK_W      (LINK_W),
        .START_W     (START_W),
        .SIZE_W      (SIZE_W)
    ) u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_start (rd_start),
        .rd_size  (rd_size),
        .rd_free  (rd_free),
        .rd_owner (rd_owner),
        .rd_link  (rd_link),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_start (wr_start),
        .wr_size  (wr_size),
        .wr_free  (wr_free),
        .wr_owner (wr_owner),
        .wr_link  (wr_link),
        .use_set  (use_set),
        .use_clr  (use_clr),
        .use_idx  (use_idx),
        .scan_idx (scan_idx_reg),
        .scan_used(scan_used)
    );

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign s_fire    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_start_address = m_addr_reg;

    assign rd_link_idx = rd_link[IDX_W-1:0];
    assign hit_alloc   = rd_free && (CMP_W'(rd_size) >= CMP_W'(req_reg));
    assign hit_free    = !rd_free && (rd_owner == owner_reg);
    assign better      = !pick_valid_reg || (rd_size < pick_size_reg);
    assign walk_last   = (rd_link == LINK_NONE) || (steps_reg == WALK_LAST);
    assign co_last     = (rd_link == LINK_NONE) || (steps_reg == CO_LAST);
    assign merged      = c_free_reg && rd_free;
    assign split_start = START_W'(64'(pick_start_reg) + 64'(req_reg));
    assign split_size  = SIZE_W'(CMP_W'(pick_size_reg) - CMP_W'(req_reg));
    assign res_start_ext = 64'(res_start_reg);

    // memory port control and sequencing
    always_comb begin
        state_next = state_reg;
        rd_en      = 1'b0;
        rd_addr    = rd_link_idx;
        wr_en      = 1'b0;
        wr_addr    = cur_reg;
        wr_start   = c_start_reg;
        wr_size    = c_size_reg;
        wr_free    = c_free_reg;
        wr_owner   = c_owner_reg;
        wr_link    = c_link_reg;
        use_set    = 1'b0;
        use_clr    = 1'b0;
        use_idx    = nx_reg;
        unique case (state_reg)
            S_IDLE: begin
                rd_addr = '0;
                if (s_fire) begin
                    rd_en = 1'b1;
                    if (s_operation == OP_ALLOC || s_operation == OP_FREE) begin
                        state_next = S_WALK;
                    end else if (s_operation == OP_COALESCE) begin
                        state_next = S_CO_FIRST;
                    end else begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_WALK: begin
                if (op_reg == OP_FREE) begin
                    if (hit_free) begin
                        wr_en      = 1'b1;
                        wr_start   = rd_start;
                        wr_size    = rd_size;
                        wr_free    = 1'b1;
                        wr_owner   = '0;
                        wr_link    = rd_link;
                        state_next = S_FINISH;
                    end else if (walk_last) begin
                        state_next = S_FINISH;
                    end else begin
                        rd_en = 1'b1;
                    end
                end else begin
                    if ((hit_alloc && fit_mode_reg == FIT_FIRST) || walk_last) begin
                        state_next = S_PLACE;
                    end else begin
                        rd_en = 1'b1;
                    end
                end
            end
            S_PLACE: begin
                if (!pick_valid_reg) begin
                    state_next = S_FINISH;
                end else if (CMP_W'(pick_size_reg) > CMP_W'(req_reg)) begin
                    if (!scan_busy_reg) begin
                        state_next = scan_found_reg ? S_SPLIT_NEW : S_FINISH;
                    end
                end else begin
                    state_next = S_SPLIT_OWN;
                end
            end
            S_SPLIT_NEW: begin
                wr_en      = 1'b1;
                wr_addr    = scan_idx_reg;
                wr_start   = split_start;
                wr_size    = split_size;
                wr_free    = 1'b1;
                wr_owner   = '0;
                wr_link    = pick_link_reg;
                use_set    = 1'b1;
                use_idx    = scan_idx_reg;
                state_next = S_SPLIT_OWN;
            end
            S_SPLIT_OWN: begin
                wr_en      = 1'b1;
                wr_addr    = pick_idx_reg;
                wr_start   = pick_start_reg;
                wr_size    = own_size_reg;
                wr_free    = 1'b0;
                wr_owner   = owner_reg;
                wr_link    = own_link_reg;
                state_next = S_FINISH;
            end
            S_CO_FIRST: begin
                if (rd_link == LINK_NONE) begin
                    state_next = S_CO_END;
                end else begin
                    rd_en      = 1'b1;
                    state_next = S_CO_WALK;
                end
            end
            S_CO_WALK: begin
                if (merged) begin
                    use_clr = 1'b1;
                end else begin
                    wr_en = 1'b1;
                end
                if (co_last) begin
                    state_next = S_CO_END;
                end else begin
                    rd_en = 1'b1;
                end
            end
            S_CO_END: begin
                wr_en      = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            fit_mode_reg <= FIT_FIRST;
            m_valid_reg  <= 1'b0;
            scan_busy_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                fit_mode_reg <= cfg_fit_mode;
            end
            if (state_reg == S_FINISH && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            // unused-entry scan, one entry a cycle, runs alongside the walk
            if (s_fire) begin
                scan_busy_reg <= 1'b1;
            end else if (scan_busy_reg && (!scan_used || scan_idx_reg == SCAN_LAST)) begin
                scan_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            scan_idx_reg   <= '0;
            scan_found_reg <= 1'b0;
        end else if (scan_busy_reg) begin
            if (!scan_used) begin
                scan_found_reg <= 1'b1;
            end else if (scan_idx_reg != SCAN_LAST) begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
            end
        end
        if (state_reg == S_FINISH && out_free) begin
            m_status_reg <= res_status_reg;
            m_addr_reg   <= (res_status_reg == ST_DONE) ? res_start_ext[ADDR_W-1:0] : '0;
        end
        unique case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    op_reg         <= s_operation;
                    owner_reg      <= s_owner_id;
                    req_reg        <= s_request_size;
                    cur_reg        <= '0;
                    steps_reg      <= '0;
                    pick_valid_reg <= 1'b0;
                    res_status_reg <= ST_DONE;
                    res_start_reg  <= '0;
                end
            end
            S_WALK: begin
                steps_reg <= steps_reg + 1'b1;
                cur_reg   <= rd_link_idx;
                if (op_reg == OP_FREE) begin
                    if (hit_free) begin
                        res_start_reg <= rd_start;
                    end else if (walk_last) begin
                        res_status_reg <= ST_NOT_FOUND;
                    end
                end else if (hit_alloc && (fit_mode_reg == FIT_FIRST || better)) begin
                    pick_valid_reg <= 1'b1;
                    pick_idx_reg   <= cur_reg;
                    pick_start_reg <= rd_start;
                    pick_size_reg  <= rd_size;
                    pick_link_reg  <= rd_link;
                end
            end
            S_PLACE: begin
                if (!pick_valid_reg) begin
                    res_status_reg <= ST_NO_FIT;
                end else if (CMP_W'(pick_size_reg) > CMP_W'(req_reg)) begin
                    own_size_reg <= SIZE_W'(req_reg);
                    own_link_reg <= LINK_W'(scan_idx_reg);
                    if (!scan_busy_reg && !scan_found_reg) begin
                        res_status_reg <= ST_FULL;
                    end
                end else begin
                    own_size_reg <= pick_size_reg;
                    own_link_reg <= pick_link_reg;
                end
            end
            S_SPLIT_OWN: begin
                res_start_reg <= pick_start_reg;
            end
            S_CO_FIRST: begin
                c_start_reg <= rd_start;
                c_size_reg  <= rd_size;
                c_free_reg  <= rd_free;
                c_owner_reg <= rd_owner;
                c_link_reg  <= rd_link;
                cur_reg     <= '0;
                nx_reg      <= rd_link_idx;
                steps_reg   <= '0;
            end
            S_CO_WALK: begin
                steps_reg <= steps_reg + 1'b1;
                nx_reg    <= rd_link_idx;
                if (merged) begin
                    c_size_reg <= c_size_reg + rd_size;
                    c_link_reg <= rd_link;
                end else begin
                    c_start_reg <= rd_start;
                    c_size_reg  <= rd_size;
                    c_free_reg  <= rd_free;
                    c_owner_reg <= rd_owner;
                    c_link_reg  <= rd_link;
                    cur_reg     <= nx_reg;
                end
            end
            S_SPLIT_NEW, S_CO_END, S_FINISH: begin
            end
            default: begin
            end
        endcase
    end

    `SAFBF_ASSERT_NXT(a_busy_after_accept, aclk, aresetn, s_fire, !s_ready)
    `SAFBF_ASSERT_IMP(a_error_addr_zero, aclk, aresetn,
        m_valid && m_status != ST_DONE, m_start_address == '0)
    `SAFBF_ASSERT_IMP(a_no_same_entry_rw, aclk, aresetn, rd_en && wr_en, rd_addr != wr_addr)
    `SAFBF_ASSERT_IMP(a_split_has_entry, aclk, aresetn,
        state_reg == S_SPLIT_NEW, scan_found_reg && !scan_busy_reg)

endmodule
